// File: hw/rtl/asau_pkg.sv
// Package for the ATA sector address unit.
// Holds item structs, geometry struct, code constants and reset values.
// No dependencies.
`default_nettype none

package asau_pkg;

  // Item kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_RESOLVE = 2'd1;
  localparam logic [1:0] KIND_ADVANCE = 2'd2;

  // Task-file register selects
  localparam logic [1:0] SEL_SECTOR   = 2'd0;
  localparam logic [1:0] SEL_CYL_LOW  = 2'd1;
  localparam logic [1:0] SEL_CYL_HIGH = 2'd2;
  localparam logic [1:0] SEL_HEAD     = 2'd3;

  // Configuration register indexes (word address)
  localparam logic [1:0] CFG_CYLINDERS = 2'd0;
  localparam logic [1:0] CFG_HEADS     = 2'd1;
  localparam logic [1:0] CFG_SPT       = 2'd2;
  localparam logic [1:0] CFG_TOTAL     = 2'd3;

  localparam int unsigned PADDR_W = 4;

  // Head/device register layout
  localparam int unsigned LBA_BIT = 6;

  // Shared multiply-add widths: (cyl*heads + head) fits 21 bits,
  // the full CHS index fits 29 bits.
  localparam int unsigned MAC_A_W = 21;
  localparam int unsigned MAC_B_W = 8;
  localparam int unsigned IDX_W   = 29;

  // Reset geometry
  localparam logic [15:0] RST_CYLINDERS = 16'd1024;
  localparam logic [4:0]  RST_HEADS     = 5'd16;
  localparam logic [7:0]  RST_SPT       = 8'd63;
  localparam logic [28:0] RST_TOTAL     = 29'd1032192;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] reg_select;
    logic [7:0] value;
  } asau_in_t;

  typedef struct packed {
    logic [27:0] sector_index;
    logic        address_error;
    logic [7:0]  sector_reg;
    logic [7:0]  cyl_low_reg;
    logic [7:0]  cyl_high_reg;
    logic [7:0]  head_reg;
  } asau_out_t;

  typedef struct packed {
    logic [15:0] cylinder_count;
    logic [4:0]  head_count;
    logic [7:0]  sectors_per_track;
    logic [28:0] total_sectors;
  } asau_geom_t;

endpackage

`default_nettype wire

// File: hw/rtl/ata_sector_address_unit.sv
// Top level of the ATA sector address unit.
// Depends on asau_pkg, asau_regs and asau_mac.
//
// Keeps the task-file address registers (sector, cylinder low/high,
// head/device) and turns them into a linear sector index. Each input item
// is a register write, a resolve or an advance, and yields exactly one
// result item carrying the last good index, an error flag and the four
// registers as they stand after the item. The block takes one item at a
// time: writes, advances and LBA resolves go straight from the accept to
// the final step, which loads the output register; a CHS resolve first
// passes through two multiply-add steps, since (cyl*heads + head) and
// then (...)*spt + sector-1 go through one shared 21x8 multiply-add unit
// in two passes. A result waiting at the output register does not block
// the next accept; the next item only holds in its final step until the
// output is taken. Geometry comes from the APB registers (cylinders at
// 0x0, heads 0x4, sectors per track 0x8, total sectors 0xC) and should be
// written while the block is idle.
`default_nettype none

module ata_sector_address_unit
  import asau_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input items
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire asau_in_t           in_item_i,
  // result items
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output asau_out_t               out_item_o,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_HEAD,
    ST_MUL_SECT,
    ST_COMMIT
  } state_e;

  state_e     state_q;
  asau_geom_t geom;
  asau_in_t   item_q;

  // task-file stores
  logic [7:0]  sector_q, cyl_low_q, cyl_high_q, head_q;
  logic [27:0] resolved_q;

  // output register
  logic      out_valid_q;
  asau_out_t out_q;

  // next values computed for the item in flight
  logic [7:0]  sector_d, cyl_low_d, cyl_high_d, head_d;
  logic [27:0] resolved_d;
  logic        err_d;

  logic        accept;
  logic        commit;

  // shared multiply-add operands
  logic               mac_en;
  logic [MAC_A_W-1:0] mac_a;
  logic [MAC_B_W-1:0] mac_b;
  logic [MAC_B_W-1:0] mac_c;
  logic [IDX_W-1:0]   mac_p;

  // address decode helpers
  logic [27:0] lba;
  logic [27:0] lba_inc;
  logic [15:0] cyl;
  logic [15:0] cyl_inc;
  logic [3:0]  hd;
  logic [4:0]  hd_inc;
  logic [8:0]  sec_inc;
  logic [7:0]  sec_m1;
  logic        is_lba;
  logic        chs_range_err;

  asau_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom_o  (geom)
  );

  asau_mac u_mac (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .c_i   (mac_c),
    .p_o   (mac_p)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  // final step waits only if the previous result is still unread
  assign commit      = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign is_lba  = head_q[LBA_BIT];
  assign hd      = head_q[3:0];
  assign cyl     = {cyl_high_q, cyl_low_q};
  assign lba     = {hd, cyl_high_q, cyl_low_q, sector_q};
  assign lba_inc = lba + 28'd1;
  assign cyl_inc = cyl + 16'd1;
  assign hd_inc  = {1'b0, hd} + 5'd1;
  assign sec_inc = {1'b0, sector_q} + 9'd1;
  assign sec_m1  = sector_q - 8'd1;

  // sector zero and a zero geometry register fall out as range errors
  assign chs_range_err = (cyl >= geom.cylinder_count)
                      || ({1'b0, hd} >= geom.head_count)
                      || (sector_q == 8'd0)
                      || (sec_m1 >= geom.sectors_per_track);

  // multiply-add sequencing: first pass cyl*heads + head,
  // second pass (first result)*spt + sector-1
  always_comb begin
    mac_en = 1'b0;
    mac_a  = '0;
    mac_b  = '0;
    mac_c  = '0;
    unique case (state_q)
      ST_MUL_HEAD: begin
        mac_en = 1'b1;
        mac_a  = MAC_A_W'(cyl);
        mac_b  = MAC_B_W'(geom.head_count);
        mac_c  = MAC_B_W'(hd);
      end
      ST_MUL_SECT: begin
        mac_en = 1'b1;
        mac_a  = mac_p[MAC_A_W-1:0];
        mac_b  = geom.sectors_per_track;
        mac_c  = sec_m1;
      end
      default: ;
    endcase
  end

  // item update
  always_comb begin
    sector_d   = sector_q;
    cyl_low_d  = cyl_low_q;
    cyl_high_d = cyl_high_q;
    head_d     = head_q;
    resolved_d = resolved_q;
    err_d      = 1'b0;
    unique case (item_q.kind)
      KIND_WRITE: begin
        unique case (item_q.reg_select)
          SEL_SECTOR:   sector_d   = item_q.value;
          SEL_CYL_LOW:  cyl_low_d  = item_q.value;
          SEL_CYL_HIGH: cyl_high_d = item_q.value;
          SEL_HEAD:     head_d     = item_q.value;
          default:      ;
        endcase
      end
      KIND_RESOLVE: begin
        if (is_lba) begin
          if ({1'b0, lba} < geom.total_sectors) begin
            resolved_d = lba;
          end else begin
            err_d = 1'b1;
          end
        end else begin
          if (!chs_range_err && (mac_p < geom.total_sectors)) begin
            resolved_d = mac_p[27:0];
          end else begin
            err_d = 1'b1;
          end
        end
      end
      KIND_ADVANCE: begin
        if (is_lba) begin
          // 28-bit wrap, upper head bits kept
          sector_d   = lba_inc[7:0];
          cyl_low_d  = lba_inc[15:8];
          cyl_high_d = lba_inc[23:16];
          head_d     = {head_q[7:4], lba_inc[27:24]};
        end else if (sec_inc > {1'b0, geom.sectors_per_track}) begin
          sector_d = 8'd1;
          if ((hd_inc >= geom.head_count) || hd_inc[4]) begin
            head_d     = {head_q[7:4], 4'd0};
            cyl_low_d  = cyl_inc[7:0];
            cyl_high_d = cyl_inc[15:8];
          end else begin
            head_d = {head_q[7:4], hd_inc[3:0]};
          end
        end else begin
          sector_d = sec_inc[7:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sector_q    <= 8'd1;
      cyl_low_q   <= 8'd0;
      cyl_high_q  <= 8'd0;
      head_q      <= 8'd0;
      resolved_q  <= 28'd0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if ((in_item_i.kind == KIND_RESOLVE) && !is_lba) begin
              state_q <= ST_MUL_HEAD;
            end else begin
              state_q <= ST_COMMIT;
            end
          end
        end
        ST_MUL_HEAD: state_q <= ST_MUL_SECT;
        ST_MUL_SECT: state_q <= ST_COMMIT;
        ST_COMMIT: begin
          if (commit) begin
            state_q     <= ST_IDLE;
            sector_q    <= sector_d;
            cyl_low_q   <= cyl_low_d;
            cyl_high_q  <= cyl_high_d;
            head_q      <= head_d;
            resolved_q  <= resolved_d;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // result payload, loaded with the committed values
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q.sector_index  <= resolved_d;
      out_q.address_error <= err_d;
      out_q.sector_reg    <= sector_d;
      out_q.cyl_low_reg   <= cyl_low_d;
      out_q.cyl_high_reg  <= cyl_high_d;
      out_q.head_reg      <= head_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/asau_regs.sv
// APB geometry registers for the ATA sector address unit.
// Depends on asau_pkg.
`default_nettype none

module asau_regs
  import asau_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output asau_geom_t              geom_o
);

  asau_geom_t geom_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign geom_o  = geom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.cylinder_count    <= RST_CYLINDERS;
      geom_q.head_count        <= RST_HEADS;
      geom_q.sectors_per_track <= RST_SPT;
      geom_q.total_sectors     <= RST_TOTAL;
    end else if (wr_en) begin
      unique case (reg_idx)
        CFG_CYLINDERS: geom_q.cylinder_count    <= pwdata[15:0];
        CFG_HEADS:     geom_q.head_count        <= pwdata[4:0];
        CFG_SPT:       geom_q.sectors_per_track <= pwdata[7:0];
        CFG_TOTAL:     geom_q.total_sectors     <= pwdata[28:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      CFG_CYLINDERS: prdata = {16'd0, geom_q.cylinder_count};
      CFG_HEADS:     prdata = {27'd0, geom_q.head_count};
      CFG_SPT:       prdata = {24'd0, geom_q.sectors_per_track};
      CFG_TOTAL:     prdata = {3'd0, geom_q.total_sectors};
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/asau_mac.sv
// Shared multiply-add unit with registered result: p = a*b + c.
// Depends on asau_pkg.
`default_nettype none

module asau_mac
  import asau_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [MAC_A_W-1:0] a_i,
  input  wire logic [MAC_B_W-1:0] b_i,
  input  wire logic [MAC_B_W-1:0] c_i,
  output logic [IDX_W-1:0]        p_o
);

  logic [IDX_W-1:0] p_d;
  logic [IDX_W-1:0] p_q;

  assign p_d = IDX_W'(IDX_W'(a_i) * IDX_W'(b_i)) + IDX_W'(c_i);
  assign p_o = p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/asau_checker.sv
// Port-level checks for the ATA sector address unit, bound to the top level.
// Depends on asau_pkg.
`default_nettype none

module asau_checker
  import asau_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire asau_in_t  in_item_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire asau_out_t out_item_o
);

  // a result is held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("stalled result changed");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  // the final step always follows the accept, never coincides with it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early after accept");

  // an item that is not a resolve never raises an error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.kind != KIND_RESOLVE)
      |=> ##1 !(out_valid_o && out_item_o.address_error && $rose(out_valid_o)))
    else $error("error flagged on an item that is not a resolve");

endmodule

bind ata_sector_address_unit asau_checker u_asau_checker (.*);

`default_nettype wire
